// ----- src/tgf_pkg.sv -----
// shared types, codes and helpers for the grouped fifo
package tgf_pkg;

    localparam int ID_W = 10;
    localparam int KIND_W = 2;
    localparam int STATUS_W = 2;

    localparam int DEF_ELEMENT_IDS = 1024;
    localparam int DEF_TEAMS = 1024;
    localparam int DEF_CAPACITY = 1024;

    localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   element;
        logic [ID_W-1:0]   team;
    } in_t;

    typedef struct packed {
        logic                has_element;
        logic [ID_W-1:0]     element_out;
        logic [STATUS_W-1:0] status;
    } out_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } eng_ctrl_t;

    typedef struct packed {
        logic ready;
        logic done;
    } eng_stat_t;

    // binary reduction: subtract modulus shifted down from the top bit
    function automatic logic [ID_W-1:0] id_mod(logic [ID_W-1:0] value, int modulus);
        logic [ID_W-1:0] v;
        int              k;
        v = value;
        for (k = ID_W - 1; k >= 0; k--) begin
            if (int'(v) >= (modulus << k)) begin
                v = v - ID_W'(modulus << k);
            end
        end
        return v;
    endfunction

endpackage

// ----- src/tgf_engine.sv -----
// request sequencer with the group table and slot table memories
module tgf_engine #(
    parameter int ELEMENT_IDS = tgf_pkg::DEF_ELEMENT_IDS,
    parameter int TEAMS = tgf_pkg::DEF_TEAMS,
    parameter int CAPACITY = tgf_pkg::DEF_CAPACITY
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tgf_pkg::eng_ctrl_t ctrl,
    input  tgf_pkg::in_t      req,
    output tgf_pkg::eng_stat_t stat,
    output tgf_pkg::out_t     res
);

    localparam int GRP_DEPTH = (ELEMENT_IDS > TEAMS) ? ELEMENT_IDS : TEAMS;
    localparam int GW = $clog2(GRP_DEPTH);
    localparam int TW = $clog2(TEAMS);
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OCW = $clog2(TEAMS + 1);

    typedef struct packed {
        logic [TW-1:0] mem_team;
        logic          waiting;
        logic [SW-1:0] first;
        logic [SW-1:0] last;
        logic [TW-1:0] next;
    } grp_entry_t;

    typedef struct packed {
        logic [tgf_pkg::ID_W-1:0] value;
        logic [SW-1:0]            link;
    } slot_entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ASSIGN,
        ST_ENQ_RD,
        ST_ENQ_ALLOC,
        ST_ENQ_TEAM,
        ST_ENQ_LINK,
        ST_DEQ_RD,
        ST_DEQ_SLOT,
        ST_DEQ_WR,
        ST_RESP
    } state_t;

    grp_entry_t  grp_mem [GRP_DEPTH];
    slot_entry_t slot_mem [CAPACITY];

    state_t        state_reg;
    logic [GW-1:0] clr_reg;
    tgf_pkg::in_t  req_reg;
    logic [TW-1:0] t_reg;
    logic [SW-1:0] slot_reg;
    logic          from_list_reg;
    logic [CW-1:0] hw_reg;
    logic [SW-1:0] free_head_reg;
    logic [CW-1:0] free_cnt_reg;
    logic [TW-1:0] head_reg;
    logic [TW-1:0] tail_reg;
    logic [OCW-1:0] ocnt_reg;
    tgf_pkg::out_t res_reg;
    grp_entry_t    grp_rd_reg;
    slot_entry_t   slot_rd_reg;

    logic          grp_ren;
    logic [GW-1:0] grp_raddr;
    logic          grp_we_mem;
    logic          grp_we_team;
    logic          grp_we_next;
    logic [GW-1:0] grp_waddr;
    grp_entry_t    grp_wdata;
    logic          slot_ren;
    logic [SW-1:0] slot_raddr;
    logic          slot_we_val;
    logic          slot_we_link;
    logic [SW-1:0] slot_waddr;
    slot_entry_t   slot_wdata;
    logic          done;

    assign done = (state_reg == ST_RESP) && ctrl.out_free;
    assign stat.ready = (state_reg == ST_IDLE);
    assign stat.done = done;
    assign res = res_reg;

    always_comb begin
        grp_ren = 1'b0;
        grp_raddr = '0;
        grp_we_mem = 1'b0;
        grp_we_team = 1'b0;
        grp_we_next = 1'b0;
        grp_waddr = '0;
        grp_wdata = '0;
        slot_ren = 1'b0;
        slot_raddr = free_head_reg;
        slot_we_val = 1'b0;
        slot_we_link = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        case (state_reg)
            ST_CLEAR: begin
                grp_we_mem = 1'b1;
                grp_we_team = 1'b1;
                grp_we_next = 1'b1;
                grp_waddr = clr_reg;
            end
            ST_ASSIGN: begin
                grp_we_mem = 1'b1;
                grp_waddr = GW'(req_reg.element);
                grp_wdata.mem_team = TW'(req_reg.team);
            end
            ST_ENQ_RD: begin
                grp_ren = 1'b1;
                grp_raddr = GW'(req_reg.element);
                slot_ren = 1'b1;
                slot_raddr = free_head_reg;
            end
            ST_ENQ_ALLOC: begin
                grp_ren = 1'b1;
                grp_raddr = GW'(grp_rd_reg.mem_team);
                slot_we_val = 1'b1;
                slot_we_link = 1'b1;
                slot_waddr = slot_reg;
                slot_wdata.value = req_reg.element;
            end
            ST_ENQ_TEAM: begin
                grp_we_team = 1'b1;
                grp_waddr = GW'(t_reg);
                grp_wdata.waiting = 1'b1;
                grp_wdata.last = slot_reg;
                if (grp_rd_reg.waiting) begin
                    grp_wdata.first = grp_rd_reg.first;
                    slot_we_link = 1'b1;
                    slot_waddr = grp_rd_reg.last;
                    slot_wdata.link = slot_reg;
                end else begin
                    grp_wdata.first = slot_reg;
                end
            end
            ST_ENQ_LINK: begin
                grp_we_next = 1'b1;
                grp_waddr = GW'(tail_reg);
                grp_wdata.next = t_reg;
            end
            ST_DEQ_RD: begin
                grp_ren = 1'b1;
                grp_raddr = GW'(head_reg);
            end
            ST_DEQ_SLOT: begin
                slot_ren = 1'b1;
                slot_raddr = grp_rd_reg.first;
            end
            ST_DEQ_WR: begin
                grp_we_team = 1'b1;
                grp_waddr = GW'(head_reg);
                grp_wdata.last = grp_rd_reg.last;
                if (grp_rd_reg.first == grp_rd_reg.last) begin
                    grp_wdata.waiting = 1'b0;
                    grp_wdata.first = grp_rd_reg.first;
                end else begin
                    grp_wdata.waiting = 1'b1;
                    grp_wdata.first = slot_rd_reg.link;
                end
                slot_we_link = 1'b1;
                slot_waddr = grp_rd_reg.first;
                slot_wdata.link = free_head_reg;
            end
            default: begin
            end
        endcase
    end

    // group table: membership, team fields and order link written separately
    always_ff @(posedge aclk) begin
        if (grp_we_mem) begin
            grp_mem[grp_waddr].mem_team <= grp_wdata.mem_team;
        end
        if (grp_we_team) begin
            grp_mem[grp_waddr].waiting <= grp_wdata.waiting;
            grp_mem[grp_waddr].first <= grp_wdata.first;
            grp_mem[grp_waddr].last <= grp_wdata.last;
        end
        if (grp_we_next) begin
            grp_mem[grp_waddr].next <= grp_wdata.next;
        end
        if (grp_ren) begin
            grp_rd_reg <= grp_mem[grp_raddr];
        end
    end

    // slot table: element value and link to the next slot
    always_ff @(posedge aclk) begin
        if (slot_we_val) begin
            slot_mem[slot_waddr].value <= slot_wdata.value;
        end
        if (slot_we_link) begin
            slot_mem[slot_waddr].link <= slot_wdata.link;
        end
        if (slot_ren) begin
            slot_rd_reg <= slot_mem[slot_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            hw_reg <= '0;
            free_head_reg <= '0;
            free_cnt_reg <= CW'(CAPACITY);
            head_reg <= '0;
            tail_reg <= '0;
            ocnt_reg <= '0;
            from_list_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == GW'(GRP_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (ctrl.start) begin
                        req_reg <= req;
                        case (req.kind)
                            tgf_pkg::KIND_ASSIGN: begin
                                res_reg <= '0;
                                state_reg <= ST_ASSIGN;
                            end
                            tgf_pkg::KIND_ENQUEUE: begin
                                if (free_cnt_reg == '0) begin
                                    res_reg <= {1'b0, {tgf_pkg::ID_W{1'b0}},
                                                tgf_pkg::STATUS_FULL};
                                    state_reg <= ST_RESP;
                                end else begin
                                    res_reg <= '0;
                                    state_reg <= ST_ENQ_RD;
                                end
                            end
                            tgf_pkg::KIND_DEQUEUE: begin
                                if (ocnt_reg == '0) begin
                                    res_reg <= {1'b0, {tgf_pkg::ID_W{1'b0}},
                                                tgf_pkg::STATUS_EMPTY};
                                    state_reg <= ST_RESP;
                                end else begin
                                    res_reg <= '0;
                                    state_reg <= ST_DEQ_RD;
                                end
                            end
                            default: begin
                                res_reg <= '0;
                                state_reg <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_ASSIGN: begin
                    state_reg <= ST_RESP;
                end
                ST_ENQ_RD: begin
                    from_list_reg <= (hw_reg == CW'(CAPACITY));
                    slot_reg <= (hw_reg == CW'(CAPACITY)) ? free_head_reg : SW'(hw_reg);
                    state_reg <= ST_ENQ_ALLOC;
                end
                ST_ENQ_ALLOC: begin
                    t_reg <= grp_rd_reg.mem_team;
                    free_cnt_reg <= free_cnt_reg - 1'b1;
                    if (from_list_reg) begin
                        free_head_reg <= slot_rd_reg.link;
                    end else begin
                        hw_reg <= hw_reg + 1'b1;
                    end
                    state_reg <= ST_ENQ_TEAM;
                end
                ST_ENQ_TEAM: begin
                    if (grp_rd_reg.waiting) begin
                        state_reg <= ST_RESP;
                    end else if (ocnt_reg == '0) begin
                        head_reg <= t_reg;
                        tail_reg <= t_reg;
                        ocnt_reg <= ocnt_reg + 1'b1;
                        state_reg <= ST_RESP;
                    end else begin
                        state_reg <= ST_ENQ_LINK;
                    end
                end
                ST_ENQ_LINK: begin
                    tail_reg <= t_reg;
                    ocnt_reg <= ocnt_reg + 1'b1;
                    state_reg <= ST_RESP;
                end
                ST_DEQ_RD: begin
                    state_reg <= ST_DEQ_SLOT;
                end
                ST_DEQ_SLOT: begin
                    state_reg <= ST_DEQ_WR;
                end
                ST_DEQ_WR: begin
                    if (grp_rd_reg.first == grp_rd_reg.last) begin
                        head_reg <= grp_rd_reg.next;
                        ocnt_reg <= ocnt_reg - 1'b1;
                    end
                    free_head_reg <= grp_rd_reg.first;
                    free_cnt_reg <= free_cnt_reg + 1'b1;
                    res_reg.has_element <= 1'b1;
                    res_reg.element_out <= slot_rd_reg.value;
                    res_reg.status <= tgf_pkg::STATUS_OK;
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    if (ctrl.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_start_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> state_reg == ST_IDLE)
        else $error("request started while engine busy");

    a_deq_gives_element: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DEQ_WR |=> res_reg.has_element && state_reg == ST_RESP)
        else $error("dequeue of waiting team returned no element");

    a_enq_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ENQ_RD |-> free_cnt_reg != '0)
        else $error("enqueue allocating with no free slot");

    a_list_after_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ENQ_ALLOC && from_list_reg |-> hw_reg == CW'(CAPACITY))
        else $error("free list used before fresh slots ran out");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt_reg <= CW'(CAPACITY) && ocnt_reg <= OCW'(TEAMS))
        else $error("slot or team count out of range");
`endif

endmodule

// ----- src/team_grouped_fifo.sv -----
// grouped fifo top level: request intake, id reduction and result register
//
// s_valid/s_ready/s_data carry one request (kind, element, team); every
// accepted request gives exactly one result on m_valid/m_ready/m_data.
// kind assign sets the team of an element id, enqueue places the element
// behind the last waiting member of its team (or its team joins the back
// of the team order), dequeue returns the front element of the front team.
// a dequeue on an empty queue reports status empty, an enqueue with no free
// slot reports status full; both leave the contents unchanged.
// one request is worked at a time, paced by dependent registered reads of
// the group and slot memories; kind 3 and flagged requests go straight to
// the result, and an enqueue takes an extra step to link its team when it
// joins a nonempty team order.
// s_ready rises with m_valid, so the next request is not accepted before
// the result of the last one is valid.
// after reset the group table is swept to zero, one entry a cycle, across
// all max(ELEMENT_IDS, TEAMS) entries with s_ready low.
// a stalled result waits in the output register; the next request is taken
// meanwhile and its result is held until m_ready frees that register.
module team_grouped_fifo #(
    parameter int ELEMENT_IDS = tgf_pkg::DEF_ELEMENT_IDS,
    parameter int TEAMS = tgf_pkg::DEF_TEAMS,
    parameter int CAPACITY = tgf_pkg::DEF_CAPACITY
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tgf_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tgf_pkg::out_t m_data
);

    tgf_pkg::eng_ctrl_t eng_ctrl;
    tgf_pkg::eng_stat_t eng_stat;
    tgf_pkg::in_t       eng_req;
    tgf_pkg::out_t      eng_res;
    logic               m_valid_reg;
    tgf_pkg::out_t      m_data_reg;

    assign s_ready = eng_stat.ready;
    assign eng_ctrl.start = s_valid && eng_stat.ready;
    assign eng_ctrl.out_free = !m_valid_reg || m_ready;

    // ids outside the store wrap into range
    assign eng_req.kind = s_data.kind;
    assign eng_req.element = tgf_pkg::id_mod(s_data.element, ELEMENT_IDS);
    assign eng_req.team = tgf_pkg::id_mod(s_data.team, TEAMS);

    tgf_engine #(
        .ELEMENT_IDS(ELEMENT_IDS),
        .TEAMS(TEAMS),
        .CAPACITY(CAPACITY)
    ) u_engine (
        .aclk(aclk),
        .aresetn(aresetn),
        .ctrl(eng_ctrl),
        .req(eng_req),
        .stat(eng_stat),
        .res(eng_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (eng_stat.done) begin
                m_valid_reg <= 1'b1;
                m_data_reg <= eng_res;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

// ----- tb/team_grouped_fifo_tb.sv -----
// self-checking testbench for the grouped fifo: queue-fed driver, predictor and result monitor
module team_grouped_fifo_tb;

    localparam int CAPACITY = tgf_pkg::DEF_CAPACITY;
    localparam int TEAMS = tgf_pkg::DEF_TEAMS;
    localparam int ELEMENT_IDS = tgf_pkg::DEF_ELEMENT_IDS;
    localparam int ID_W = tgf_pkg::ID_W;
    localparam int KIND_W = tgf_pkg::KIND_W;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD = 3000;
    localparam int HOLD_AT = 150;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    tgf_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tgf_pkg::out_t m_data;

    team_grouped_fifo u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // predicted block state
    logic [ID_W-1:0] team_of_id [ELEMENT_IDS];
    logic [ID_W-1:0] team_ring [TEAMS];
    logic [ID_W-1:0] ring_head;
    logic [ID_W-1:0] ring_tail;
    logic [ID_W:0]   ring_len;
    logic [ID_W-1:0] head_slot [TEAMS];
    logic [ID_W-1:0] tail_slot [TEAMS];
    logic            team_active [TEAMS];
    logic [ID_W-1:0] slot_elem [CAPACITY];
    logic [ID_W-1:0] slot_next [CAPACITY];
    logic [ID_W-1:0] free_stack [CAPACITY];
    logic [ID_W:0]   free_top;

    tgf_pkg::in_t  request_q [$];
    tgf_pkg::out_t expected_q [$];

    int errors = 0;
    int sent_count = 0;
    int got_count = 0;
    int total_reqs = 0;
    int used_slots = 0;
    int cycles = 0;

    int tx_wait = 0;
    int tx_left = 0;
    bit tx_calm = 1'b0;
    int rx_wait = 0;
    int rx_left = 0;
    bit rx_calm = 1'b0;
    int next_wait;

    task automatic clear_model();
        for (int i = 0; i < CAPACITY; i++) begin
            free_stack[i] = ID_W'(i);
            slot_elem[i] = '0;
            slot_next[i] = '0;
        end
        for (int i = 0; i < TEAMS; i++) begin
            team_ring[i] = '0;
            head_slot[i] = '0;
            tail_slot[i] = '0;
            team_active[i] = 1'b0;
        end
        for (int i = 0; i < ELEMENT_IDS; i++) team_of_id[i] = '0;
        ring_head = '0;
        ring_tail = '0;
        ring_len = '0;
        free_top = (ID_W+1)'(CAPACITY);
    endtask

    task automatic apply_request(input tgf_pkg::in_t req, output tgf_pkg::out_t res);
        logic [ID_W-1:0] grp;
        logic [ID_W-1:0] slot;
        res = '0;
        res.status = tgf_pkg::STATUS_OK;
        case (req.kind)
            tgf_pkg::KIND_ASSIGN: team_of_id[req.element] = req.team;
            tgf_pkg::KIND_ENQUEUE: begin
                grp = team_of_id[req.element];
                if (free_top == 0) begin
                    res.status = tgf_pkg::STATUS_FULL;
                end else begin
                    free_top = free_top - 1'b1;
                    slot = free_stack[free_top[ID_W-1:0]];
                    slot_elem[slot] = req.element;
                    slot_next[slot] = '0;
                    if (team_active[grp]) begin
                        slot_next[tail_slot[grp]] = slot;
                        tail_slot[grp] = slot;
                    end else begin
                        team_active[grp] = 1'b1;
                        head_slot[grp] = slot;
                        tail_slot[grp] = slot;
                        team_ring[ring_tail] = grp;
                        ring_tail = ring_tail + 1'b1;
                        ring_len = ring_len + 1'b1;
                    end
                end
            end
            tgf_pkg::KIND_DEQUEUE: begin
                if (ring_len == 0) begin
                    res.status = tgf_pkg::STATUS_EMPTY;
                end else begin
                    grp = team_ring[ring_head];
                    slot = head_slot[grp];
                    res.has_element = 1'b1;
                    res.element_out = slot_elem[slot];
                    if (slot == tail_slot[grp]) begin
                        team_active[grp] = 1'b0;
                        ring_head = ring_head + 1'b1;
                        ring_len = ring_len - 1'b1;
                    end else begin
                        head_slot[grp] = slot_next[slot];
                    end
                    if (free_top < CAPACITY) begin
                        free_stack[free_top[ID_W-1:0]] = slot;
                        free_top = free_top + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_req(input logic [KIND_W-1:0] kind, input int elem, input int grp);
        tgf_pkg::in_t req;
        req.kind = kind;
        req.element = ID_W'(elem);
        req.team = ID_W'(grp);
        request_q.insert(request_q.size(), req);
        if (kind == tgf_pkg::KIND_ENQUEUE && used_slots < CAPACITY) used_slots++;
        if (kind == tgf_pkg::KIND_DEQUEUE && used_slots > 0) used_slots--;
    endtask

    // mostly a small id pool at both ends of the range so assigns matter
    function automatic int pick_element();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(0, 31);
        if (r < 8) return 10'h3E0 | $urandom_range(0, 31);
        return $urandom_range(0, 1023);
    endfunction

    function automatic int pick_team();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 7) | ($urandom_range(0, 1) ? 10'h3F8 : 10'h000);
        return $urandom_range(0, 1023);
    endfunction

    task automatic push_mixed(input int p_assign, input int p_enq, input int p_deq);
        int r;
        r = $urandom_range(0, 99);
        if (r < p_assign)
            push_req(tgf_pkg::KIND_ASSIGN, pick_element(), pick_team());
        else if (r < p_enq)
            push_req(tgf_pkg::KIND_ENQUEUE, pick_element(), $urandom_range(0, 1023));
        else if (r < p_deq)
            push_req(tgf_pkg::KIND_DEQUEUE, $urandom_range(0, 1023), $urandom_range(0, 1023));
        else
            push_req(KIND_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    // idle stretches alternate with runs of back-to-back traffic
    function automatic int draw_wait(inout int left, inout bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 2) == 0);
            left = $urandom_range(10, 60);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tgf_pkg::out_t res;
                apply_request(s_data, res);
                expected_q.insert(expected_q.size(), res);
                sent_count++;
            end
            if (!(s_valid && !s_ready)) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    s_data <= request_q.pop_front();
                    s_valid <= 1'b1;
                    tx_wait = draw_wait(tx_left, tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending, actual %0h %0h %0h", $time,
                         m_data.has_element, m_data.element_out, m_data.status);
            end else begin
                tgf_pkg::out_t exp_res;
                exp_res = expected_q.pop_front();
                check_field("has_element", 16'(exp_res.has_element), 16'(m_data.has_element));
                check_field("element_out", 16'(exp_res.element_out), 16'(m_data.element_out));
                check_field("status", 16'(exp_res.status), 16'(m_data.status));
            end
            got_count++;
            next_wait = (got_count == HOLD_AT) ? LONG_HOLD : draw_wait(rx_left, rx_calm);
            rx_wait = next_wait;
            m_ready <= (next_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= (rx_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            cycles <= cycles + 1;
        end
    end

    initial begin
        clear_model();

        // directed: empty dequeue, unused kind, extreme ids, team joins and leaves
        push_req(tgf_pkg::KIND_DEQUEUE, 1023, 1023);
        push_req(KIND_UNUSED, 1023, 1023);
        push_req(tgf_pkg::KIND_ASSIGN, 1023, 1023);
        push_req(tgf_pkg::KIND_ASSIGN, 5, 1023);
        push_req(tgf_pkg::KIND_ASSIGN, 6, 2);
        push_req(tgf_pkg::KIND_ENQUEUE, 1023, 0);
        push_req(tgf_pkg::KIND_ENQUEUE, 0, 1023);
        push_req(tgf_pkg::KIND_ENQUEUE, 6, 0);
        push_req(tgf_pkg::KIND_ENQUEUE, 5, 0);
        push_req(tgf_pkg::KIND_ENQUEUE, 7, 0);
        push_req(tgf_pkg::KIND_DEQUEUE, 0, 0);
        push_req(tgf_pkg::KIND_DEQUEUE, 0, 0);
        push_req(tgf_pkg::KIND_DEQUEUE, 0, 0);
        push_req(tgf_pkg::KIND_DEQUEUE, 0, 0);
        push_req(tgf_pkg::KIND_DEQUEUE, 0, 0);
        push_req(tgf_pkg::KIND_DEQUEUE, 0, 0);
        push_req(tgf_pkg::KIND_ASSIGN, 1023, 0);
        push_req(tgf_pkg::KIND_ENQUEUE, 1023, 1023);
        push_req(tgf_pkg::KIND_ENQUEUE, 5, 0);
        push_req(tgf_pkg::KIND_DEQUEUE, 1023, 1023);
        push_req(tgf_pkg::KIND_DEQUEUE, 0, 0);
        push_req(tgf_pkg::KIND_DEQUEUE, 0, 0);
        push_req(KIND_UNUSED, 0, 0);

        repeat (300) push_mixed(25, 65, 95);

        // fill the slot store, then probe the full boundary
        while (used_slots < CAPACITY) begin
            if ($urandom_range(0, 9) == 0)
                push_req(tgf_pkg::KIND_ASSIGN, pick_element(), pick_team());
            else
                push_req(tgf_pkg::KIND_ENQUEUE, pick_element(), $urandom_range(0, 1023));
        end
        repeat (5) begin
            push_req(tgf_pkg::KIND_ENQUEUE, pick_element(), $urandom_range(0, 1023));
            push_req(tgf_pkg::KIND_DEQUEUE, $urandom_range(0, 1023), $urandom_range(0, 1023));
            push_req(tgf_pkg::KIND_ENQUEUE, pick_element(), $urandom_range(0, 1023));
            push_req(tgf_pkg::KIND_ENQUEUE, pick_element(), $urandom_range(0, 1023));
        end

        repeat (200) push_mixed(15, 40, 95);
        total_reqs = request_q.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (sent_count < total_reqs || expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/tgf_pkg.sv
src/tgf_engine.sv
src/team_grouped_fifo.sv
tb/team_grouped_fifo_tb.sv
